// ===== sv/rqv_pkg.sv =====
// ----------------------------------------------------------------------------
// rqv_pkg
// Shared widths, constants, types and the corner order for the rotated quad
// vertex expander.
// ----------------------------------------------------------------------------
package rqv_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int COORD_IN_W     = 24;
  localparam int SIZE_W         = 23;
  localparam int COORD_OUT_W    = 26;
  localparam int TRIG_W         = 17;
  localparam int PROD_W         = 41;
  localparam int ACC_W          = 43;

  localparam logic [31:0] DEFAULT_RGBA_RST = 32'hFFFFFF4D;

  // polynomial constants for sin(z*pi/2), q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [17:0] ONE_Q15 = 18'd32768;

  localparam logic [2:0] VERT_LAST = 3'd5;

  typedef struct packed {
    logic signed [COORD_IN_W-1:0] px;
    logic signed [COORD_IN_W-1:0] py;
    logic [SIZE_W-1:0]            w;
    logic [SIZE_W-1:0]            h;
    logic [31:0]                  rgba;
  } rect_t;

  typedef struct packed {
    logic [3:0][COORD_OUT_W-1:0] vx;
    logic [3:0][COORD_OUT_W-1:0] vy;
    logic [31:0]                 rgba;
  } quad_t;

  // corner used by each of the six vertices
  function automatic logic [1:0] corner_sel(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd1;
      3'd4: c = 2'd3;
      3'd5: c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/rqv_trig.sv =====
// ----------------------------------------------------------------------------
// rqv_trig
// Five-stage sine and cosine pipeline: quadrant folding, then the quarter-wave
// polynomial one multiplication per stage, two lanes side by side.
// ----------------------------------------------------------------------------
module rqv_trig #(
  parameter int ANGLE_BITS = rqv_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ANGLE_BITS-1:0]             in_angle,
  input  rqv_pkg::rect_t                    in_rect,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rqv_pkg::TRIG_W-1:0] out_sin,
  output logic signed [rqv_pkg::TRIG_W-1:0] out_cos,
  output rqv_pkg::rect_t                    out_rect
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  // lane 0 sine, lane 1 cosine
  logic [16:0] z1_r [2];
  logic        n1_r [2];
  logic [16:0] z2_r [2];
  logic [16:0] sq2_r [2];
  logic        n2_r [2];
  logic [16:0] z3_r [2];
  logic [16:0] sq3_r [2];
  logic [15:0] inner3_r [2];
  logic        n3_r [2];
  logic [16:0] z4_r [2];
  logic [16:0] mid4_r [2];
  logic        n4_r [2];
  logic signed [rqv_pkg::TRIG_W-1:0] res5_r [2];

  rqv_pkg::rect_t rect1_r, rect2_r, rect3_r, rect4_r, rect5_r;

  logic [31:0] turn;
  logic [1:0]  quad [2];
  logic [16:0] z_fold [2];
  logic [33:0] p2 [2];
  logic [33:0] p3 [2];
  logic [33:0] p4 [2];
  logic [34:0] p5 [2];
  logic [17:0] r5 [2];
  logic [16:0] r5_sat [2];
  logic [16:0] t3 [2];
  logic [16:0] t4 [2];

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    turn    = 32'(in_angle) << (32 - ANGLE_BITS);
    quad[0] = turn[31:30];
    quad[1] = turn[31:30] + 2'd1;
    for (int i = 0; i < 2; i++) begin
      z_fold[i] = quad[i][0] ? (17'd65536 - {1'b0, turn[29:14]}) : {1'b0, turn[29:14]};
      p2[i]     = 34'(z1_r[i]) * 34'(z1_r[i]) + 34'd32768;
      p3[i]     = 34'(sq2_r[i]) * 34'(rqv_pkg::SIN_C) + 34'd32768;
      t3[i]     = p3[i][32:16];
      p4[i]     = 34'(sq3_r[i]) * 34'(inner3_r[i]) + 34'd32768;
      t4[i]     = p4[i][32:16];
      p5[i]     = 35'(z4_r[i]) * 35'(mid4_r[i]) + 35'd65536;
      r5[i]     = p5[i][34:17];
      r5_sat[i] = (r5[i] > rqv_pkg::ONE_Q15) ? 17'(rqv_pkg::ONE_Q15) : r5[i][16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rect1_r <= in_rect;
      for (int i = 0; i < 2; i++) begin
        z1_r[i] <= z_fold[i];
        n1_r[i] <= quad[i][1];
      end
    end
    if (en2) begin
      rect2_r <= rect1_r;
      for (int i = 0; i < 2; i++) begin
        z2_r[i]  <= z1_r[i];
        sq2_r[i] <= p2[i][32:16];
        n2_r[i]  <= n1_r[i];
      end
    end
    if (en3) begin
      rect3_r <= rect2_r;
      for (int i = 0; i < 2; i++) begin
        z3_r[i]     <= z2_r[i];
        sq3_r[i]    <= sq2_r[i];
        inner3_r[i] <= 16'(17'(rqv_pkg::SIN_B) - t3[i]);
        n3_r[i]     <= n2_r[i];
      end
    end
    if (en4) begin
      rect4_r <= rect3_r;
      for (int i = 0; i < 2; i++) begin
        z4_r[i]   <= z3_r[i];
        mid4_r[i] <= rqv_pkg::SIN_A - t4[i];
        n4_r[i]   <= n3_r[i];
      end
    end
    if (en5) begin
      rect5_r <= rect4_r;
      for (int i = 0; i < 2; i++) begin
        res5_r[i] <= n4_r[i] ? -$signed(r5_sat[i]) : $signed(r5_sat[i]);
      end
    end
  end

  assign out_valid = v5_r;
  assign out_sin   = res5_r[0];
  assign out_cos   = res5_r[1];
  assign out_rect  = rect5_r;

endmodule

// ===== sv/rqv_geom.sv =====
// ----------------------------------------------------------------------------
// rqv_geom
// Three-stage corner pipeline: size by sine and cosine products, rotated half
// extents and center, then the four corners rounded to q.8.
// ----------------------------------------------------------------------------
module rqv_geom (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rqv_pkg::TRIG_W-1:0] in_sin,
  input  logic signed [rqv_pkg::TRIG_W-1:0] in_cos,
  input  rqv_pkg::rect_t                    in_rect,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rqv_pkg::quad_t                    out_quad
);

  localparam int AW = rqv_pkg::ACC_W;
  localparam int PW = rqv_pkg::PROD_W;

  logic v6_r, v7_r, v8_r;
  logic en6, en7, en8;

  logic signed [PW-1:0] wc6_r, hs6_r, ws6_r, hc6_r;
  logic signed [AW-1:0] cx6_r, cy6_r;
  logic [31:0]          rgba6_r;

  logic signed [AW-1:0] rx7_r, ry7_r, rx27_r, ry27_r, cx7_r, cy7_r;
  logic [31:0]          rgba7_r;

  rqv_pkg::quad_t quad8_r;

  logic signed [rqv_pkg::SIZE_W:0] ws, hs;
  logic signed [PW-1:0] wc, hsn, wsn, hc;
  logic signed [AW-1:0] cx, cy;
  logic signed [AW-1:0] sx [4];
  logic signed [AW-1:0] sy [4];
  rqv_pkg::quad_t quad_nxt;

  assign en8      = !v8_r || out_ready;
  assign en7      = !v7_r || en8;
  assign en6      = !v6_r || en7;
  assign in_ready = en6;

  always_comb begin
    ws  = $signed({1'b0, in_rect.w});
    hs  = $signed({1'b0, in_rect.h});
    wc  = ws * in_cos;
    hsn = hs * in_sin;
    wsn = ws * in_sin;
    hc  = hs * in_cos;
    cx  = (AW'(in_rect.px) <<< 16) + (AW'(ws) <<< 15);
    cy  = (AW'(in_rect.py) <<< 16) + (AW'(hs) <<< 15);
  end

  always_comb begin
    sx[0] = cx7_r - rx7_r  + AW'(32768);
    sy[0] = cy7_r - ry7_r  + AW'(32768);
    sx[1] = cx7_r + rx27_r + AW'(32768);
    sy[1] = cy7_r + ry27_r + AW'(32768);
    sx[2] = cx7_r - rx27_r + AW'(32768);
    sy[2] = cy7_r - ry27_r + AW'(32768);
    sx[3] = cx7_r + rx7_r  + AW'(32768);
    sy[3] = cy7_r + ry7_r  + AW'(32768);
    quad_nxt.rgba = rgba7_r;
    for (int k = 0; k < 4; k++) begin
      quad_nxt.vx[k] = sx[k][rqv_pkg::COORD_OUT_W+15:16];
      quad_nxt.vy[k] = sy[k][rqv_pkg::COORD_OUT_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en6) v6_r <= in_valid;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      wc6_r   <= wc;
      hs6_r   <= hsn;
      ws6_r   <= wsn;
      hc6_r   <= hc;
      cx6_r   <= cx;
      cy6_r   <= cy;
      rgba6_r <= in_rect.rgba;
    end
    if (en7) begin
      rx7_r   <= AW'(wc6_r) - AW'(hs6_r);
      ry7_r   <= AW'(ws6_r) + AW'(hc6_r);
      rx27_r  <= AW'(wc6_r) + AW'(hs6_r);
      ry27_r  <= AW'(ws6_r) - AW'(hc6_r);
      cx7_r   <= cx6_r;
      cy7_r   <= cy6_r;
      rgba7_r <= rgba6_r;
    end
    if (en8) begin
      quad8_r <= quad_nxt;
    end
  end

  assign out_valid = v8_r;
  assign out_quad  = quad8_r;

endmodule

// ===== sv/rqv_emit.sv =====
// ----------------------------------------------------------------------------
// rqv_emit
// Holds one finished quad and hands out its six vertices, one per
// transaction, taking the next quad as the sixth vertex leaves.
// ----------------------------------------------------------------------------
module rqv_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rqv_pkg::quad_t                      in_quad,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rqv_pkg::COORD_OUT_W-1:0]     out_vert_x,
  output logic [rqv_pkg::COORD_OUT_W-1:0]     out_vert_y,
  output logic [31:0]                         out_rgba,
  output logic [2:0]                          out_vertex_number,
  output logic                                out_last
);

  logic           hold_v_r, hold_v_nxt;
  logic [2:0]     k_r, k_nxt;
  rqv_pkg::quad_t quad_r;
  logic           load;
  logic [1:0]     corner;

  assign in_ready = !hold_v_r || (out_ready && (k_r == rqv_pkg::VERT_LAST));
  assign load     = in_valid && in_ready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    k_nxt      = k_r;
    if (load) begin
      hold_v_nxt = 1'b1;
      k_nxt      = 3'd0;
    end else if (hold_v_r && out_ready) begin
      if (k_r == rqv_pkg::VERT_LAST) begin
        hold_v_nxt = 1'b0;
        k_nxt      = 3'd0;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      k_r      <= 3'd0;
    end else begin
      hold_v_r <= hold_v_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) quad_r <= in_quad;
  end

  assign corner            = rqv_pkg::corner_sel(k_r);
  assign out_valid         = hold_v_r;
  assign out_vert_x        = quad_r.vx[corner];
  assign out_vert_y        = quad_r.vy[corner];
  assign out_rgba          = quad_r.rgba;
  assign out_vertex_number = k_r;
  assign out_last          = (k_r == rqv_pkg::VERT_LAST);

endmodule

// ===== sv/rotated_quad_vertex_expander_top.sv =====
// ----------------------------------------------------------------------------
// rotated_quad_vertex_expander_top
// Turns one rectangle transaction into six colored vertex transactions.
// ----------------------------------------------------------------------------
// A rectangle (q16.8 corner, q15.8 size, binary angle, optional color) goes
// through eight register stages: five for sine and cosine (quadrant folding,
// then one polynomial multiply per stage), three for the size products, the
// rotated extents with the center, and the rounded corners, and then into the
// vertex register. Vertices leave one per cycle while out_ready is high; the
// single vertex port sets the sustained rectangle rate, and the next rectangle
// is taken while earlier ones are still in the pipe. Vertices come in the order
// bottom-left, bottom-right, top-left, bottom-right, top-right, top-left. The
// default color register is written with cfg_we and applies to rectangles
// without their own color.
module rotated_quad_vertex_expander_top #(
  parameter int ANGLE_BITS = rqv_pkg::ANGLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [31:0]                            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rqv_pkg::COORD_IN_W-1:0]  in_pos_x,
  input  logic signed [rqv_pkg::COORD_IN_W-1:0]  in_pos_y,
  input  logic [rqv_pkg::SIZE_W-1:0]             in_width,
  input  logic [rqv_pkg::SIZE_W-1:0]             in_height,
  input  logic [ANGLE_BITS-1:0]                  in_angle,
  input  logic                                   in_has_own_color,
  input  logic [7:0]                             in_red_in,
  input  logic [7:0]                             in_green_in,
  input  logic [7:0]                             in_blue_in,
  input  logic [7:0]                             in_alpha_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rqv_pkg::COORD_OUT_W-1:0] out_vert_x,
  output logic signed [rqv_pkg::COORD_OUT_W-1:0] out_vert_y,
  output logic [7:0]                             out_red_out,
  output logic [7:0]                             out_green_out,
  output logic [7:0]                             out_blue_out,
  output logic [7:0]                             out_alpha_out,
  output logic [2:0]                             out_vertex_number,
  output logic                                   out_last
);

  logic [31:0] default_rgba_r;

  rqv_pkg::rect_t rect_in;
  rqv_pkg::rect_t trig_rect;
  rqv_pkg::quad_t geom_quad;

  logic                              trig_valid, trig_ready;
  logic signed [rqv_pkg::TRIG_W-1:0] trig_sin, trig_cos;
  logic                              geom_valid, geom_ready;
  logic [rqv_pkg::COORD_OUT_W-1:0]   vx, vy;
  logic [31:0]                       rgba;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_rgba_r <= rqv_pkg::DEFAULT_RGBA_RST;
    end else if (cfg_we) begin
      default_rgba_r <= cfg_wdata;
    end
  end

  always_comb begin
    rect_in.px   = in_pos_x;
    rect_in.py   = in_pos_y;
    rect_in.w    = in_width;
    rect_in.h    = in_height;
    rect_in.rgba = in_has_own_color ? {in_red_in, in_green_in, in_blue_in, in_alpha_in}
                                    : default_rgba_r;
  end

  rqv_trig #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_angle (in_angle),
    .in_rect  (rect_in),
    .out_valid(trig_valid),
    .out_ready(trig_ready),
    .out_sin  (trig_sin),
    .out_cos  (trig_cos),
    .out_rect (trig_rect)
  );

  rqv_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (trig_valid),
    .in_ready (trig_ready),
    .in_sin   (trig_sin),
    .in_cos   (trig_cos),
    .in_rect  (trig_rect),
    .out_valid(geom_valid),
    .out_ready(geom_ready),
    .out_quad (geom_quad)
  );

  rqv_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (geom_valid),
    .in_ready         (geom_ready),
    .in_quad          (geom_quad),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vert_x       (vx),
    .out_vert_y       (vy),
    .out_rgba         (rgba),
    .out_vertex_number(out_vertex_number),
    .out_last         (out_last)
  );

  assign out_vert_x    = $signed(vx);
  assign out_vert_y    = $signed(vy);
  assign out_red_out   = rgba[31:24];
  assign out_green_out = rgba[23:16];
  assign out_blue_out  = rgba[15:8];
  assign out_alpha_out = rgba[7:0];

endmodule
